@@ rtl/lgs_pkg.sv @@
// Shared types and constants for the life generation step block.
`timescale 1ns / 1ps

package lgs_pkg;

  // Fixed field widths of the transaction ports
  localparam int IDX_W   = 4;
  localparam int CELLS_W = 10;

  // func codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  // Control group from the sequencer to the row store
  typedef struct packed {
    logic load;   // write one row at the load address
    logic shift;  // move rows one place toward the head, append new row at tail
  } grid_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_STEP = 2'b10
  } state_t;

endpackage

@@ rtl/lgs_rule.sv @@
// Next-generation row from three adjacent grid rows under rule B3/S23.
`timescale 1ns / 1ps

module lgs_rule #(
  parameter int COLS = 10
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] mid,
  input  logic [COLS-1:0] below,
  output logic [COLS-1:0] new_row
);
  import lgs_pkg::*;

  // dead padding column on each side
  logic [COLS+1:0] above_p;
  logic [COLS+1:0] mid_p;
  logic [COLS+1:0] below_p;

  assign above_p = {1'b0, above, 1'b0};
  assign mid_p   = {1'b0, mid, 1'b0};
  assign below_p = {1'b0, below, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    logic [3:0] cnt;
    assign cnt = 4'(above_p[c]) + 4'(above_p[c+1]) + 4'(above_p[c+2])
               + 4'(mid_p[c])                      + 4'(mid_p[c+2])
               + 4'(below_p[c]) + 4'(below_p[c+1]) + 4'(below_p[c+2]);
    assign new_row[c] = (cnt == BIRTH_COUNT) | ((cnt == KEEP_COUNT) & mid[c]);
  end

endmodule

@@ rtl/lgs_grid.sv @@
// Row store: shift line of grid rows, random row write, head taps for the step walk.
`timescale 1ns / 1ps

module lgs_grid #(
  parameter int ROWS   = 10,
  parameter int COLS   = 10,
  parameter int RIDX_W = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lgs_pkg::grid_ctl_t      ctl,
  input  logic [RIDX_W-1:0]       load_addr,
  input  logic [COLS-1:0]         load_row,
  input  logic [COLS-1:0]         ins_row,
  output logic [COLS-1:0]         head_row,
  output logic [COLS-1:0]         second_row
);
  import lgs_pkg::*;

  logic [COLS-1:0] rows_r   [ROWS];
  logic [COLS-1:0] rows_nxt [ROWS];

  always_comb begin
    rows_nxt = rows_r;
    if (ctl.shift) begin
      for (int i = 0; i < ROWS - 1; i++) begin
        rows_nxt[i] = rows_r[i+1];
      end
      rows_nxt[ROWS-1] = ins_row;
    end else if (ctl.load) begin
      rows_nxt[load_addr] = load_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        rows_r[i] <= '0;
      end
    end else begin
      rows_r <= rows_nxt;
    end
  end

  assign head_row   = rows_r[0];
  assign second_row = rows_r[1];

endmodule

@@ rtl/life_generation_step.sv @@
// Top level of the life generation step block: sequencer, row store and output register.
`timescale 1ns / 1ps
//
// Game of Life (B3/S23) on a ROWS x COLS grid, dead cells beyond the edges.
// Input channel (in_valid / in_stall): one transaction is either a load
// (in_func = load) that writes row in_row_index with in_row_cells, or a step
// (in_func = step) that advances the grid one generation. Loads with an
// index >= ROWS are dropped; cell bits at column COLS and above are dropped.
// Output channel (out_valid / out_stall): a step produces ROWS transactions,
// rows 0..ROWS-1 in order, out_last_row set on the final one. Loads produce none.
// Flow: a load writes its row straight into the row store. A step walks the grid
// one row per cycle, while the output register is free or being drained, through
// the row shift line; the first row passes the state register and then the output
// register after the step is accepted, and the next input is taken only once the
// walk of all ROWS rows has ended. The single row-rule unit, one row a cycle, sets it.
// in_stall is high for the whole step walk. When the receiver stalls, the
// output register holds its row and the walk pauses until it is taken.
// Reset (rst_n low, synchronous) clears every cell and drops any pending row.
//
module life_generation_step #(
  parameter int ROWS = 10,
  parameter int COLS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [lgs_pkg::IDX_W-1:0]   in_row_index,
  input  logic [lgs_pkg::CELLS_W-1:0] in_row_cells,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lgs_pkg::IDX_W-1:0]   out_row,
  output logic [lgs_pkg::CELLS_W-1:0] out_cells,
  output logic                        out_last_row
);
  import lgs_pkg::*;

  localparam int RIDX_W = $clog2(ROWS);

  state_t              state_r, state_nxt;
  logic [RIDX_W-1:0]   cnt_r, cnt_nxt;        // row being evaluated
  logic [COLS-1:0]     above_r, above_nxt;    // old row above the current one

  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_row_r, out_row_nxt;
  logic [CELLS_W-1:0]  out_cells_r, out_cells_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_xact;
  logic                load_ok;
  logic                advance;
  logic                last_cnt;
  grid_ctl_t           grid_ctl;
  logic [RIDX_W-1:0]   load_addr;
  logic [COLS-1:0]     load_row;
  logic [COLS-1:0]     head_row;
  logic [COLS-1:0]     second_row;
  logic [COLS-1:0]     below_row;
  logic [COLS-1:0]     new_row;
  logic [CELLS_W-1:0]  new_cells;

  // Column mapping between the fixed-width ports and the grid width
  for (genvar c = 0; c < COLS; c++) begin : g_ld
    if (c < CELLS_W) begin : g_in
      assign load_row[c] = in_row_cells[c];
    end else begin : g_pad
      assign load_row[c] = 1'b0;
    end
  end

  for (genvar c = 0; c < CELLS_W; c++) begin : g_out
    if (c < COLS) begin : g_in
      assign new_cells[c] = new_row[c];
    end else begin : g_pad
      assign new_cells[c] = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xact   = in_valid && !in_stall;
  assign load_ok   = int'(in_row_index) < ROWS;
  assign load_addr = RIDX_W'(in_row_index);

  // One row evaluated per cycle while the output slot is free or being drained
  assign advance  = (state_r == ST_STEP) && (!out_valid_r || !out_stall);
  assign last_cnt = (cnt_r == RIDX_W'(ROWS - 1));

  // Rows at and behind position 1 are already new on the final row: use dead edge
  assign below_row = last_cnt ? '0 : second_row;

  assign grid_ctl.shift = advance;
  assign grid_ctl.load  = in_xact && (in_func == FUNC_LOAD) && load_ok;

  lgs_grid #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .RIDX_W (RIDX_W)
  ) u_grid (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (grid_ctl),
    .load_addr  (load_addr),
    .load_row   (load_row),
    .ins_row    (new_row),
    .head_row   (head_row),
    .second_row (second_row)
  );

  lgs_rule #(
    .COLS (COLS)
  ) u_rule (
    .above   (above_r),
    .mid     (head_row),
    .below   (below_row),
    .new_row (new_row)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    above_nxt = above_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xact && (in_func == FUNC_STEP)) begin
          state_nxt = ST_STEP;
          cnt_nxt   = '0;
          above_nxt = '0;   // dead row above row 0
        end
      end
      ST_STEP: begin
        if (advance) begin
          above_nxt = head_row;
          cnt_nxt   = cnt_r + 1'b1;
          if (last_cnt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_cells_nxt = out_cells_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = IDX_W'(cnt_r);
      out_cells_nxt = new_cells;
      out_last_nxt  = last_cnt;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    above_r     <= above_nxt;
    out_row_r   <= out_row_nxt;
    out_cells_r <= out_cells_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_row      = out_row_r;
  assign out_cells    = out_cells_r;
  assign out_last_row = out_last_r;

endmodule

@@ rtl/lgs_chk.sv @@
// Port-level checker for the life generation step block and its bind.
`timescale 1ns / 1ps

module lgs_chk #(
  parameter int ROWS = 10
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lgs_pkg::IDX_W-1:0]   out_row,
  input logic [lgs_pkg::CELLS_W-1:0] out_cells,
  input logic                        out_last_row
);
  import lgs_pkg::*;

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_cells)
      && $stable(out_last_row))
    else $error("stalled output changed");

  // Final row of a generation carries row ROWS-1
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row |-> out_row == IDX_W'(ROWS - 1))
    else $error("last_row flag on wrong row");

  // Rows of one generation follow back to back in ascending order
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_row |=>
      out_valid && out_row == IDX_W'($past(out_row) + 1'b1))
    else $error("row sequence broken");

  // Input is held off while a generation is still being emitted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |-> in_stall)
    else $error("input taken during step walk");

endmodule

bind life_generation_step lgs_chk #(.ROWS(ROWS)) u_lgs_chk (.*);
